// ===== rtl/odo_pkg.sv =====
// shared types, constants and tables for the differential drive odometry block
`default_nettype none
package odo_pkg;

    // field and register widths
    localparam int TICK_W = 16;
    localparam int CFG_W = 24;
    localparam int CFG_IDX_W = 2;
    localparam int POSE_W = 48;
    localparam int HEAD_W = 32;
    localparam int CORDIC_STEPS_DEF = 24;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_PER_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_PER_COUNT = 2'd1;
    localparam logic [CFG_W-1:0] DIST_PER_COUNT_RST = 24'd256216;
    localparam logic [CFG_W-1:0] HEAD_PER_COUNT_RST = 24'd745654;

    // shared multiplier: 64 x 41 bit, one 16 bit digit of a per cycle
    localparam int MUL_A_W = 64;
    localparam int MUL_B_W = 41;
    localparam int MUL_P_W = 106;
    localparam int MUL_DIG_W = 16;
    localparam int MUL_DIGITS = MUL_A_W / MUL_DIG_W;

    // datapath widths
    localparam int DIST_W = 48;
    localparam int TURN_W = 57;
    localparam int HQ_W = 56;
    localparam int SQ_W = 18;
    localparam int K_W = 40;
    localparam int DK_W = 58;
    localparam int DELTA_W = 64;
    localparam int SINC_SMALL_BITS = 24;

    // cordic widths
    localparam int COR_W = 34;
    localparam int ANG_W = 33;
    localparam int STEP_CNT_W = 6;

    // divider widths
    localparam int DIV_NUM_W = 62;
    localparam int DIV_DEN_W = 56;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    // numeric constants
    localparam logic signed [MUL_B_W-1:0] PI_Q20 = MUL_B_W'(3294199);
    localparam logic signed [COR_W-1:0] CORDIC_GAIN = COR_W'(652032874);
    localparam logic signed [K_W-1:0] K_ONE = K_W'(1073741824);
    // ceil(2^21 / 6): exact floor of x / 6 for any series term below 2^18
    localparam logic signed [MUL_B_W-1:0] SIXTH_Q21 = MUL_B_W'(349526);
    localparam int SIXTH_SHIFT = 21;
    localparam logic signed [ANG_W-1:0] ANG_QUARTER = ANG_W'(1073741824);
    localparam logic signed [ANG_W-1:0] ANG_HALF = ANG_W'(34'sd2147483648);
    localparam logic signed [DELTA_W-1:0] POSE_MAX = (DELTA_W'(64'sd1) <<< (POSE_W - 1)) - 1;
    localparam logic signed [DELTA_W-1:0] POSE_MIN = -(DELTA_W'(64'sd1) <<< (POSE_W - 1));

    typedef struct packed {
        logic signed [TICK_W-1:0] ticks_left;
        logic signed [TICK_W-1:0] ticks_right;
    } sample_t;

    typedef struct packed {
        logic signed [POSE_W-1:0] pos_x;
        logic signed [POSE_W-1:0] pos_y;
        logic [HEAD_W-1:0]        heading;
        logic                     straight_move;
    } pose_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_DIST,
        OP_TURN,
        OP_HQ,
        OP_SQ,
        OP_DK,
        OP_DX,
        OP_DY,
        OP_DIV_SMALL,
        OP_DIV_BIG,
        OP_COR_SIN,
        OP_COR_MID
    } op_t;

    typedef struct packed {
        logic load;
        logic mul_go;
        logic div_go;
        logic cor_go;
        op_t  op;
        logic commit;
    } odo_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic cor_done;
        logic small_angle;
    } odo_stat_t;

    // arctangent of 2^-i, full turn is 2^32
    function automatic logic signed [ANG_W-1:0] atan_q(input logic [4:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            5'd0:    v = ANG_W'(32'h20000000);
            5'd1:    v = ANG_W'(32'h12E4051E);
            5'd2:    v = ANG_W'(32'h09FB385B);
            5'd3:    v = ANG_W'(32'h051111D4);
            5'd4:    v = ANG_W'(32'h028B0D43);
            5'd5:    v = ANG_W'(32'h0145D7E1);
            5'd6:    v = ANG_W'(32'h00A2F61E);
            5'd7:    v = ANG_W'(32'h00517C55);
            5'd8:    v = ANG_W'(32'h0028BE53);
            5'd9:    v = ANG_W'(32'h00145F2F);
            5'd10:   v = ANG_W'(32'h000A2F98);
            5'd11:   v = ANG_W'(32'h000517CC);
            5'd12:   v = ANG_W'(32'h00028BE6);
            5'd13:   v = ANG_W'(32'h000145F3);
            5'd14:   v = ANG_W'(32'h0000A2FA);
            5'd15:   v = ANG_W'(32'h0000517D);
            5'd16:   v = ANG_W'(32'h000028BE);
            5'd17:   v = ANG_W'(32'h0000145F);
            5'd18:   v = ANG_W'(32'h00000A30);
            5'd19:   v = ANG_W'(32'h00000518);
            5'd20:   v = ANG_W'(32'h0000028C);
            5'd21:   v = ANG_W'(32'h00000146);
            5'd22:   v = ANG_W'(32'h000000A3);
            5'd23:   v = ANG_W'(32'h00000051);
            5'd24:   v = ANG_W'(32'h00000029);
            5'd25:   v = ANG_W'(32'h00000014);
            5'd26:   v = ANG_W'(32'h0000000A);
            5'd27:   v = ANG_W'(32'h00000005);
            5'd28:   v = ANG_W'(32'h00000003);
            5'd29:   v = ANG_W'(32'h00000001);
            5'd30:   v = ANG_W'(32'h00000001);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/odo_mul.sv =====
// digit serial signed multiplier, one 16 bit digit of the first operand per cycle
`default_nettype none
module odo_mul (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 go,
    input  wire logic signed [odo_pkg::MUL_A_W-1:0]   a,
    input  wire logic signed [odo_pkg::MUL_B_W-1:0]   b,
    output logic                                      done,
    output logic signed [odo_pkg::MUL_P_W-1:0]        prod
);
    import odo_pkg::*;

    localparam int DIG_IDX_W = $clog2(MUL_DIGITS);
    localparam logic [DIG_IDX_W-1:0] TOP_DIG = DIG_IDX_W'(MUL_DIGITS - 1);

    logic signed [MUL_A_W-1:0]         a_reg;
    logic signed [MUL_B_W-1:0]         b_reg;
    logic signed [MUL_P_W-1:0]         acc_reg;
    logic signed [MUL_P_W-1:0]         acc_next;
    logic [DIG_IDX_W-1:0]              dig_reg;
    logic                              busy_reg;
    logic                              done_reg;
    logic [MUL_DIG_W-1:0]              dig_bits;
    logic signed [MUL_DIG_W:0]         digit;
    logic signed [MUL_DIG_W+MUL_B_W:0] pp;

    // partial product of the current digit, top digit carries the sign
    always_comb
    begin
        dig_bits = a_reg[dig_reg*MUL_DIG_W +: MUL_DIG_W];
        if (dig_reg == TOP_DIG)
        begin
            digit = signed'({dig_bits[MUL_DIG_W-1], dig_bits});
        end
        else
        begin
            digit = signed'({1'b0, dig_bits});
        end
        pp = digit * b_reg;
        acc_next = (acc_reg <<< MUL_DIG_W) + MUL_P_W'(pp);
    end

    // operand capture and accumulation, most significant digit first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg    <= '0;
            b_reg    <= '0;
            acc_reg  <= '0;
            dig_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                a_reg    <= a;
                b_reg    <= b;
                acc_reg  <= '0;
                dig_reg  <= TOP_DIG;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                acc_reg <= acc_next;
                if (dig_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    dig_reg <= dig_reg - 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule
`default_nettype wire

// ===== rtl/odo_div.sv =====
// restoring unsigned divider, one quotient bit per cycle
`default_nettype none
module odo_div (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             go,
    input  wire logic [odo_pkg::DIV_NUM_W-1:0]    num,
    input  wire logic [odo_pkg::DIV_DEN_W-1:0]    den,
    output logic                                  done,
    output logic [odo_pkg::DIV_NUM_W-1:0]         quo
);
    import odo_pkg::*;

    logic [DIV_DEN_W:0]   rem_reg;
    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W:0]   rem_next;
    logic [DIV_NUM_W-1:0] nq_reg;
    logic [DIV_NUM_W-1:0] nq_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic                 fits;

    // shift in the next numerator bit and try the subtraction
    always_comb
    begin
        rem_sh   = {rem_reg[DIV_DEN_W-1:0], nq_reg[DIV_NUM_W-1]};
        fits     = (rem_sh >= {1'b0, den_reg});
        rem_next = fits ? (rem_sh - {1'b0, den_reg}) : rem_sh;
        nq_next  = {nq_reg[DIV_NUM_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            nq_reg   <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                rem_reg  <= '0;
                nq_reg   <= num;
                den_reg  <= den;
                cnt_reg  <= DIV_CNT_W'(DIV_NUM_W - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                nq_reg  <= nq_next;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = nq_reg;

endmodule
`default_nettype wire

// ===== rtl/odo_cordic.sv =====
// iterative rotation cordic giving cosine and sine of a binary angle
`default_nettype none
module odo_cordic #(
    parameter int CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              go,
    input  wire logic [odo_pkg::HEAD_W-1:0]        ang,
    output logic                                   done,
    output logic signed [odo_pkg::COR_W-1:0]       cos_q,
    output logic signed [odo_pkg::COR_W-1:0]       sin_q
);
    import odo_pkg::*;

    logic signed [COR_W-1:0] x_reg;
    logic signed [COR_W-1:0] y_reg;
    logic signed [ANG_W-1:0] z_reg;
    logic signed [COR_W-1:0] x_next;
    logic signed [COR_W-1:0] y_next;
    logic signed [ANG_W-1:0] z_next;
    logic signed [COR_W-1:0] xs;
    logic signed [COR_W-1:0] ys;
    logic signed [ANG_W-1:0] at;
    logic signed [ANG_W-1:0] z_in;
    logic signed [ANG_W-1:0] z_fold;
    logic                    flip_in;
    logic                    flip_reg;
    logic [STEP_CNT_W-1:0]   cnt_reg;
    logic [4:0]              sh;
    logic                    busy_reg;
    logic                    done_reg;

    // fold the start angle into the right half plane
    always_comb
    begin
        z_in    = ANG_W'(signed'(ang));
        z_fold  = z_in;
        flip_in = 1'b0;
        if (z_in > ANG_QUARTER)
        begin
            z_fold  = z_in - ANG_HALF;
            flip_in = 1'b1;
        end
        else if (z_in < -ANG_QUARTER)
        begin
            z_fold  = z_in + ANG_HALF;
            flip_in = 1'b1;
        end
    end

    // one micro-rotation
    always_comb
    begin
        sh = cnt_reg[4:0];
        xs = x_reg >>> sh;
        ys = y_reg >>> sh;
        at = atan_q(sh);
        if (!z_reg[ANG_W-1])
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - at;
        end
        else
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + at;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            y_reg    <= '0;
            z_reg    <= '0;
            flip_reg <= 1'b0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                x_reg    <= CORDIC_GAIN;
                y_reg    <= '0;
                z_reg    <= z_fold;
                flip_reg <= flip_in;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                x_reg <= x_next;
                y_reg <= y_next;
                z_reg <= z_next;
                if (cnt_reg == STEP_CNT_W'(CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    // undo the fold
    assign cos_q = flip_reg ? -x_reg : x_reg;
    assign sin_q = flip_reg ? -y_reg : y_reg;
    assign done  = done_reg;

endmodule
`default_nettype wire

// ===== rtl/odo_dp.sv =====
// odometry datapath: config registers, pose state, shared multiplier, divider and cordic
`default_nettype none
module odo_dp #(
    parameter int CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire odo_pkg::odo_cmd_t                   cmd,
    output odo_pkg::odo_stat_t                       stat,
    input  wire odo_pkg::sample_t                    sample,
    input  wire logic                                cfg_valid,
    input  wire logic [odo_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [odo_pkg::CFG_W-1:0]           cfg_data,
    output odo_pkg::pose_t                           pose
);
    import odo_pkg::*;

    logic [CFG_W-1:0]          dpc_reg;
    logic [CFG_W-1:0]          hpc_reg;
    logic signed [TICK_W-1:0]  l_reg;
    logic signed [TICK_W-1:0]  r_reg;
    op_t                       op_reg;
    logic signed [DIST_W-1:0]  dist_reg;
    logic signed [TURN_W-1:0]  p_reg;
    logic [HQ_W-1:0]           hq_reg;
    logic [SQ_W-1:0]           sq_reg;
    logic signed [K_W-1:0]     k_reg;
    logic signed [COR_W-1:0]   ss_reg;
    logic signed [DK_W-1:0]    dk_reg;
    logic signed [COR_W-1:0]   cm_reg;
    logic signed [COR_W-1:0]   sm_reg;
    logic signed [DELTA_W-1:0] dx_reg;
    logic signed [DELTA_W-1:0] dy_reg;
    logic signed [POSE_W-1:0]  pose_x_reg;
    logic signed [POSE_W-1:0]  pose_y_reg;
    logic [HEAD_W-1:0]         head_reg;
    pose_t                     out_reg;

    logic signed [TICK_W:0]    tick_sum;
    logic signed [TICK_W:0]    tick_diff;
    logic [HQ_W-1:0]           ap;
    logic signed [COR_W-1:0]   ss_abs;
    logic                      ss_neg;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;
    logic                      mul_done;
    logic [DIV_NUM_W-1:0]      div_num;
    logic [DIV_DEN_W-1:0]      div_den;
    logic [DIV_NUM_W-1:0]      quo;
    logic signed [K_W-1:0]     quo_k;
    logic                      div_done;
    logic [HEAD_W-1:0]         cor_ang;
    logic signed [COR_W-1:0]   cos_q;
    logic signed [COR_W-1:0]   sin_q;
    logic                      cor_done;
    logic signed [DELTA_W-1:0] x_sum;
    logic signed [DELTA_W-1:0] y_sum;
    logic signed [POSE_W-1:0]  x_sat;
    logic signed [POSE_W-1:0]  y_sat;
    logic [HEAD_W-1:0]         head_new;

    // derived operands
    always_comb
    begin
        tick_sum  = l_reg + r_reg;
        tick_diff = r_reg - l_reg;
        ap        = p_reg[TURN_W-1] ? HQ_W'(-p_reg) : HQ_W'(p_reg);
        ss_neg    = ss_reg[COR_W-1];
        ss_abs    = ss_neg ? -ss_reg : ss_reg;
        quo_k     = signed'(K_W'(quo));
    end

    // multiplier operand select
    always_comb
    begin
        case (cmd.op)
            OP_DIST:
            begin
                mul_a = MUL_A_W'(tick_sum);
                mul_b = signed'(MUL_B_W'(dpc_reg));
            end
            OP_TURN:
            begin
                mul_a = MUL_A_W'(tick_diff);
                mul_b = signed'(MUL_B_W'(hpc_reg));
            end
            OP_HQ:
            begin
                mul_a = signed'(MUL_A_W'(ap));
                mul_b = PI_Q20;
            end
            OP_SQ:
            begin
                mul_a = signed'(MUL_A_W'(hq_reg));
                mul_b = signed'(MUL_B_W'(hq_reg[SINC_SMALL_BITS-1:0]));
            end
            OP_DIV_SMALL:
            begin
                // series term over six by reciprocal multiplication
                mul_a = signed'(MUL_A_W'(sq_reg));
                mul_b = SIXTH_Q21;
            end
            OP_DK:
            begin
                mul_a = MUL_A_W'(dist_reg);
                mul_b = MUL_B_W'(k_reg);
            end
            OP_DX:
            begin
                mul_a = MUL_A_W'(dk_reg);
                mul_b = MUL_B_W'(cm_reg);
            end
            OP_DY:
            begin
                mul_a = MUL_A_W'(dk_reg);
                mul_b = MUL_B_W'(sm_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divider operands: sin over half angle
    always_comb
    begin
        div_num = {ss_abs[DIV_NUM_W-31:0], 30'd0};
        div_den = hq_reg;
    end

    // cordic angle: half the absolute turn for sinc, or mid heading
    always_comb
    begin
        if (cmd.op == OP_COR_SIN)
        begin
            cor_ang = ap[HEAD_W:1];
        end
        else
        begin
            cor_ang = head_reg + p_reg[HEAD_W:1];
        end
    end

    // pose update with saturation
    always_comb
    begin
        x_sum    = DELTA_W'(pose_x_reg) + dx_reg;
        y_sum    = DELTA_W'(pose_y_reg) + dy_reg;
        head_new = head_reg + p_reg[HEAD_W-1:0];
        if (x_sum > POSE_MAX)
        begin
            x_sat = POSE_W'(POSE_MAX);
        end
        else if (x_sum < POSE_MIN)
        begin
            x_sat = POSE_W'(POSE_MIN);
        end
        else
        begin
            x_sat = POSE_W'(x_sum);
        end
        if (y_sum > POSE_MAX)
        begin
            y_sat = POSE_W'(POSE_MAX);
        end
        else if (y_sum < POSE_MIN)
        begin
            y_sat = POSE_W'(POSE_MIN);
        end
        else
        begin
            y_sat = POSE_W'(y_sum);
        end
    end

    odo_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (cmd.mul_go),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (prod)
    );

    odo_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (cmd.div_go),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (quo)
    );

    odo_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (cmd.cor_go),
        .ang   (cor_ang),
        .done  (cor_done),
        .cos_q (cos_q),
        .sin_q (sin_q)
    );

    // config, intermediate results and pose state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dpc_reg    <= DIST_PER_COUNT_RST;
            hpc_reg    <= HEAD_PER_COUNT_RST;
            l_reg      <= '0;
            r_reg      <= '0;
            op_reg     <= OP_DIST;
            dist_reg   <= '0;
            p_reg      <= '0;
            hq_reg     <= '0;
            sq_reg     <= '0;
            k_reg      <= '0;
            ss_reg     <= '0;
            dk_reg     <= '0;
            cm_reg     <= '0;
            sm_reg     <= '0;
            dx_reg     <= '0;
            dy_reg     <= '0;
            pose_x_reg <= '0;
            pose_y_reg <= '0;
            head_reg   <= '0;
            out_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_DIST_PER_COUNT: dpc_reg <= cfg_data;
                    CFG_HEAD_PER_COUNT: hpc_reg <= cfg_data;
                    default:            ;
                endcase
            end
            if (cmd.load)
            begin
                l_reg <= sample.ticks_left;
                r_reg <= sample.ticks_right;
            end
            if (cmd.mul_go || cmd.div_go || cmd.cor_go)
            begin
                op_reg <= cmd.op;
            end
            if (mul_done)
            begin
                case (op_reg)
                    OP_DIST:      dist_reg <= DIST_W'(prod >>> 9);
                    OP_TURN:      p_reg    <= TURN_W'(prod);
                    OP_HQ:        hq_reg   <= HQ_W'(prod >>> 22);
                    OP_SQ:        sq_reg   <= SQ_W'(prod >>> 30);
                    OP_DIV_SMALL: k_reg    <= K_ONE - K_W'(prod >>> SIXTH_SHIFT);
                    OP_DK:        dk_reg   <= DK_W'(prod >>> 30);
                    OP_DX:        dx_reg   <= DELTA_W'(prod >>> 30);
                    OP_DY:        dy_reg   <= DELTA_W'(prod >>> 30);
                    default:      ;
                endcase
            end
            if (div_done)
            begin
                k_reg <= ss_neg ? -quo_k : quo_k;
            end
            if (cor_done)
            begin
                if (op_reg == OP_COR_SIN)
                begin
                    ss_reg <= sin_q;
                end
                else
                begin
                    cm_reg <= cos_q;
                    sm_reg <= sin_q;
                end
            end
            if (cmd.commit)
            begin
                pose_x_reg            <= x_sat;
                pose_y_reg            <= y_sat;
                head_reg              <= head_new;
                out_reg.pos_x         <= x_sat;
                out_reg.pos_y         <= y_sat;
                out_reg.heading       <= head_new;
                out_reg.straight_move <= (p_reg == '0);
            end
        end
    end

    assign stat.mul_done    = mul_done;
    assign stat.div_done    = div_done;
    assign stat.cor_done    = cor_done;
    assign stat.small_angle = (hq_reg[HQ_W-1:SINC_SMALL_BITS] == '0);
    assign pose             = out_reg;

endmodule
`default_nettype wire

// ===== rtl/odo_ctrl.sv =====
// odometry sequencer: walks one item through the datapath operations
`default_nettype none
module odo_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  sample_valid,
    output logic                       sample_ready,
    output logic                       pose_valid,
    input  wire logic                  pose_ready,
    input  wire odo_pkg::odo_stat_t    stat,
    output odo_pkg::odo_cmd_t          cmd
);
    import odo_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIST, S_DIST_W,
        S_TURN, S_TURN_W,
        S_HQ, S_HQ_W,
        S_SQ, S_SQ_W,
        S_DSM, S_DSM_W,
        S_CSIN, S_CSIN_W,
        S_DBIG, S_DBIG_W,
        S_DK, S_DK_W,
        S_CMID, S_CMID_W,
        S_DX, S_DX_W,
        S_DY, S_DY_W,
        S_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   pose_valid_reg;
    logic   pose_valid_next;

    // command decode and next state
    always_comb
    begin
        cmd        = '0;
        cmd.op     = OP_DIST;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = sample_valid;
                if (sample_valid)
                begin
                    state_next = S_DIST;
                end
            end
            S_DIST:
            begin
                cmd.mul_go = 1'b1;
                cmd.op     = OP_DIST;
                state_next = S_DIST_W;
            end
            S_DIST_W: if (stat.mul_done) state_next = S_TURN;
            S_TURN:
            begin
                cmd.mul_go = 1'b1;
                cmd.op     = OP_TURN;
                state_next = S_TURN_W;
            end
            S_TURN_W: if (stat.mul_done) state_next = S_HQ;
            S_HQ:
            begin
                cmd.mul_go = 1'b1;
                cmd.op     = OP_HQ;
                state_next = S_HQ_W;
            end
            S_HQ_W: if (stat.mul_done) state_next = S_SQ;
            S_SQ:
            begin
                // half angle known here: series for small turns, cordic otherwise
                if (stat.small_angle)
                begin
                    cmd.mul_go = 1'b1;
                    cmd.op     = OP_SQ;
                    state_next = S_SQ_W;
                end
                else
                begin
                    state_next = S_CSIN;
                end
            end
            S_SQ_W: if (stat.mul_done) state_next = S_DSM;
            S_DSM:
            begin
                cmd.mul_go = 1'b1;
                cmd.op     = OP_DIV_SMALL;
                state_next = S_DSM_W;
            end
            S_DSM_W: if (stat.mul_done) state_next = S_DK;
            S_CSIN:
            begin
                cmd.cor_go = 1'b1;
                cmd.op     = OP_COR_SIN;
                state_next = S_CSIN_W;
            end
            S_CSIN_W: if (stat.cor_done) state_next = S_DBIG;
            S_DBIG:
            begin
                cmd.div_go = 1'b1;
                cmd.op     = OP_DIV_BIG;
                state_next = S_DBIG_W;
            end
            S_DBIG_W: if (stat.div_done) state_next = S_DK;
            S_DK:
            begin
                cmd.mul_go = 1'b1;
                cmd.op     = OP_DK;
                state_next = S_DK_W;
            end
            S_DK_W: if (stat.mul_done) state_next = S_CMID;
            S_CMID:
            begin
                cmd.cor_go = 1'b1;
                cmd.op     = OP_COR_MID;
                state_next = S_CMID_W;
            end
            S_CMID_W: if (stat.cor_done) state_next = S_DX;
            S_DX:
            begin
                cmd.mul_go = 1'b1;
                cmd.op     = OP_DX;
                state_next = S_DX_W;
            end
            S_DX_W: if (stat.mul_done) state_next = S_DY;
            S_DY:
            begin
                cmd.mul_go = 1'b1;
                cmd.op     = OP_DY;
                state_next = S_DY_W;
            end
            S_DY_W: if (stat.mul_done) state_next = S_COMMIT;
            S_COMMIT:
            begin
                // wait for the output register to free up
                if (!pose_valid_reg || pose_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        pose_valid_next = (pose_valid_reg && !pose_ready) || cmd.commit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pose_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pose_valid_reg <= pose_valid_next;
        end
    end

    assign sample_ready = (state_reg == S_IDLE);
    assign pose_valid   = pose_valid_reg;

endmodule
`default_nettype wire

// ===== rtl/differential_drive_odometry_top.sv =====
// differential drive odometry top level: sequencer plus datapath
// one item in flight: the next item is taken only once the pose of the last one is committed,
// and the commit waits for pose_ready while the previous pose is still held on the output;
// the 62 step divider runs on the arc path only, the iterative cordic once or twice per item
// asynchronous active low reset clears the pose and loads the default per-count scales
`default_nettype none
module differential_drive_odometry_top #(
    parameter int CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             sample_valid,
    output logic                                  sample_ready,
    input  wire odo_pkg::sample_t                 sample,
    output logic                                  pose_valid,
    input  wire logic                             pose_ready,
    output odo_pkg::pose_t                        pose,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [odo_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [odo_pkg::CFG_W-1:0]        cfg_data
);
    import odo_pkg::*;

    odo_cmd_t  cmd;
    odo_stat_t stat;

    // config writes always taken
    assign cfg_ready = 1'b1;

    odo_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .pose_valid   (pose_valid),
        .pose_ready   (pose_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    odo_dp #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .sample    (sample),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pose      (pose)
    );

endmodule
`default_nettype wire
